// File: sv/awfc_pkg.sv
package awfc_pkg;

   localparam int NUM_FILTERS = 8;

   localparam logic [1:0] OP_READ   = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_SAMPLE = 2'd2;

   localparam logic [4:0] REG_INTR_STATE  = 5'd0;
   localparam logic [4:0] REG_INTR_ENABLE = 5'd1;
   localparam logic [4:0] REG_INTR_TEST   = 5'd2;
   localparam logic [4:0] REG_ALERT_TEST  = 5'd3;
   localparam logic [4:0] REG_EN_CTL      = 5'd4;
   localparam logic [4:0] REG_PD_CTL      = 5'd5;
   localparam logic [4:0] REG_LP_CNT      = 5'd6;
   localparam logic [4:0] REG_NP_CNT      = 5'd7;
   localparam logic [4:0] REG_FSM_RST     = 5'd8;
   localparam logic [4:0] REG_FILT_FIRST  = 5'd9;
   localparam logic [4:0] REG_FILT_LAST   = 5'd24;
   localparam logic [4:0] REG_CHAN0_VAL   = 5'd25;
   localparam logic [4:0] REG_CHAN1_VAL   = 5'd26;
   localparam logic [4:0] REG_WAKEUP_CTL  = 5'd27;
   localparam logic [4:0] REG_FILT_STATUS = 5'd28;
   localparam logic [4:0] REG_INTR_CTL    = 5'd29;
   localparam logic [4:0] REG_INTR_STATUS = 5'd30;
   localparam logic [4:0] REG_FSM_STATE   = 5'd31;

   localparam logic [31:0] FILT_WMASK = 32'h8ffc1ffc;
   localparam logic [31:0] PD_WMASK   = 32'hfffffff1;
   localparam logic [31:0] PD_RESET   = 32'h00064070;
   localparam logic [15:0] NP_RESET   = 16'h009b;
   localparam logic [3:0]  FSM_NP_STATE = 4'd12;
   localparam int TRANS_BIT   = 8;
   localparam int ONESHOT_BIT = 9;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [4:0]  reg_index;
      logic [31:0] write_data;
      logic [9:0]  chan0_sample;
      logic [9:0]  chan1_sample;
   } item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        intr_line;
      logic        wakeup_level;
      logic        alert_pulse;
   } result_type;

endpackage

// File: sv/adc_window_filter_controller_unit.sv
// channel | dir | tdata fields (low bit up)                            | tuser
// req     | in  | reg_index[4:0] write_data[36:5] chan0[46:37] chan1[56:47] | opcode[1:0]
// rsp     | out | read_data[31:0] intr[32] wakeup[33] alert[34]             | -
// One item per cycle sustained while rsp_tready is high; each result passes the
// front queue and then the result register of the execute stage.
// Synchronous active-high reset restores registers but not queue data or the result.
// The front queue keeps accepting while a result waits on rsp_tready, until
// its two entries fill; then req_tready drops.
module adc_window_filter_controller_unit
   import awfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // reg_index, write_data, chan0, chan1
   input  logic [1:0]  req_tuser,  // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // read_data, intr_line, wakeup, alert
);
   item_type   in_item, q_item;
   result_type res;
   logic       q_valid, q_ready;

   // unpack the transfer into an item
   always_comb begin
      in_item.opcode       = req_tuser;
      in_item.reg_index    = req_tdata[4:0];
      in_item.write_data   = req_tdata[36:5];
      in_item.chan0_sample = req_tdata[46:37];
      in_item.chan1_sample = req_tdata[56:47];
   end

   awfc_queue u_queue (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(in_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   awfc_exec u_exec (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_result(res)
   );

   assign rsp_tdata = {5'd0, res.alert_pulse, res.wakeup_level, res.intr_line,
                       res.read_data};
endmodule

// File: sv/awfc_queue.sv
module awfc_queue
   import awfc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);
   // two-entry queue, full throughput
   item_type    mem_ff [2];
   logic        wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = mem_ff[rptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) mem_ff[wptr_ff] <= in_item;
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !in_ready) else $error("queue overflow");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> cnt_ff == $past(cnt_ff) - 2'd1) else $error("pop count");
`endif
endmodule

// File: sv/awfc_exec.sv
module awfc_exec
   import awfc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  item_type   in_item,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);
   logic        ip_ff, ip_in, ie_ff, ie_in, it_ff, it_in;
   logic [1:0]  en_ff, en_in;
   logic [31:0] pd_ff, pd_in;
   logic [7:0]  lp_ff, lp_in;
   logic [15:0] np_ff, np_in;
   logic        fr_ff, fr_in;
   logic [31:0] filt_ff [16];
   logic [31:0] filt_in [16];
   logic [9:0]  c0v_ff, c0v_in, c1v_ff, c1v_in, c0l_ff, c0l_in, c1l_ff, c1l_in;
   logic [8:0]  wk_ff, wk_in, fs_ff, fs_in;
   logic [9:0]  ic_ff, ic_in, is_ff, is_in;
   logic [3:0]  st_ff, st_in;
   logic        seen_ff, seen_in;
   logic        ovalid_ff, ovalid_in;
   result_type  ores_ff, ores_in;

   logic        take, cont, any, fsm_go, en, rise;
   logic [31:0] rd;
   logic        alert;
   logic [3:0]  fidx;
   logic [NUM_FILTERS-1:0] hits;

   function automatic logic win(input logic [31:0] ctl, input logic [9:0] v);
      logic ins;
      ins = (ctl[11:2] <= v) && (v <= ctl[27:18]);
      return ctl[12] ? !ins : ins;
   endfunction

   assign in_ready   = !ovalid_ff || out_ready;
   assign take       = in_valid && in_ready;
   assign out_valid  = ovalid_ff;
   assign out_result = ores_ff;
   assign cont = en_ff[0] && !en_ff[1];
   assign fidx = in_item.reg_index[3:0] - REG_FILT_FIRST[3:0];

   always_comb begin
      for (int k = 0; k < NUM_FILTERS; k++) begin
         hits[k] = (filt_ff[k][31] || filt_ff[8+k][31])
            && (!filt_ff[k][31] || win(filt_ff[k], in_item.chan0_sample))
            && (!filt_ff[8+k][31] || win(filt_ff[8+k], in_item.chan1_sample));
      end
   end

   always_comb begin
      ip_in = ip_ff; ie_in = ie_ff; it_in = it_ff; en_in = en_ff; pd_in = pd_ff;
      lp_in = lp_ff; np_in = np_ff; fr_in = fr_ff; filt_in = filt_ff;
      c0v_in = c0v_ff; c1v_in = c1v_ff; c0l_in = c0l_ff; c1l_in = c1l_ff;
      wk_in = wk_ff; fs_in = fs_ff; ic_in = ic_ff; is_in = is_ff;
      st_in = st_ff; seen_in = seen_ff;
      rd = '0; alert = 1'b0; any = 1'b0; fsm_go = 1'b0; en = 1'b0; rise = 1'b0;
      ovalid_in = ovalid_ff && !out_ready;
      ores_in = ores_ff;
      if (take) begin
         case (in_item.opcode)
            OP_READ: begin
               case (in_item.reg_index) inside
                  [REG_FILT_FIRST:REG_FILT_LAST]: rd = filt_ff[fidx];
                  REG_INTR_STATE:  rd = {31'd0, ip_ff};
                  REG_INTR_ENABLE: rd = {31'd0, ie_ff};
                  REG_EN_CTL:      rd = {30'd0, en_ff};
                  REG_PD_CTL:      rd = pd_ff;
                  REG_LP_CNT:      rd = {24'd0, lp_ff};
                  REG_NP_CNT:      rd = {16'd0, np_ff};
                  REG_FSM_RST:     rd = {31'd0, fr_ff};
                  REG_CHAN0_VAL:   rd = {4'd0, c0l_ff, 6'd0, c0v_ff, 2'd0};
                  REG_CHAN1_VAL:   rd = {4'd0, c1l_ff, 6'd0, c1v_ff, 2'd0};
                  REG_WAKEUP_CTL:  rd = {23'd0, wk_ff};
                  REG_FILT_STATUS: rd = {23'd0, fs_ff};
                  REG_INTR_CTL:    rd = {22'd0, ic_ff};
                  REG_INTR_STATUS: rd = {22'd0, is_ff};
                  REG_FSM_STATE:   rd = {28'd0, st_ff};
                  default:         rd = '0;
               endcase
            end
            OP_WRITE: begin
               case (in_item.reg_index) inside
                  [REG_FILT_FIRST:REG_FILT_LAST]: begin
                     filt_in[fidx] = in_item.write_data & FILT_WMASK;
                     fsm_go = cont;
                  end
                  REG_INTR_STATE: begin
                     ip_in = (is_ff != '0) || it_ff;
                  end
                  REG_INTR_ENABLE: ie_in = in_item.write_data[0];
                  REG_INTR_TEST: begin
                     it_in = in_item.write_data[0];
                     ip_in = (is_ff != '0) || in_item.write_data[0];
                  end
                  REG_ALERT_TEST: alert = in_item.write_data[0];
                  REG_EN_CTL: begin
                     en_in = in_item.write_data[1:0];
                     fsm_go = 1'b1;
                  end
                  REG_PD_CTL: begin
                     pd_in = in_item.write_data & PD_WMASK;
                     fsm_go = cont;
                  end
                  REG_LP_CNT: lp_in = in_item.write_data[7:0];
                  REG_NP_CNT: np_in = in_item.write_data[15:0];
                  REG_FSM_RST: begin
                     fr_in = in_item.write_data[0];
                     fsm_go = 1'b1;
                  end
                  REG_WAKEUP_CTL: wk_in = in_item.write_data[8:0];
                  REG_FILT_STATUS: begin
                     fs_in = fs_ff & ~in_item.write_data[8:0];
                     ip_in = (is_ff != '0) || it_ff;
                  end
                  REG_INTR_CTL: begin
                     ic_in = in_item.write_data[9:0];
                     ip_in = (is_ff != '0) || it_ff;
                  end
                  REG_INTR_STATUS: begin
                     is_in = is_ff & ~in_item.write_data[9:0];
                     ip_in = (is_in != '0) || it_ff;
                  end
                  default: ;
               endcase
               // enable state machine uses the post-write registers
               if (fsm_go) begin
                  if (fr_in) begin
                     seen_in = 1'b0;
                     st_in = '0;
                  end else begin
                     en = en_in[0];
                     rise = !seen_ff && en;
                     seen_in = en;
                     if (!en) begin
                        st_in = '0;
                     end else if (en_in[1]) begin
                        if (rise) begin
                           c0v_in = in_item.chan0_sample;
                           c1v_in = in_item.chan1_sample;
                           c0l_in = in_item.chan0_sample;
                           c1l_in = in_item.chan1_sample;
                           if (ic_ff[ONESHOT_BIT]) is_in[ONESHOT_BIT] = 1'b1;
                           st_in = '0;
                           ip_in = (is_in != '0) || it_ff;
                        end
                     end else begin
                        st_in = FSM_NP_STATE;
                     end
                  end
               end
            end
            OP_SAMPLE: begin
               if (cont && !fr_ff) begin
                  any = (hits != '0);
                  fs_in[NUM_FILTERS-1:0] = fs_ff[NUM_FILTERS-1:0] | hits;
                  is_in[NUM_FILTERS-1:0] = is_ff[NUM_FILTERS-1:0]
                     | (hits & ic_ff[NUM_FILTERS-1:0]);
                  c0v_in = in_item.chan0_sample;
                  c1v_in = in_item.chan1_sample;
                  if (any) begin
                     c0l_in = in_item.chan0_sample;
                     c1l_in = in_item.chan1_sample;
                     if (pd_ff[0]) begin
                        fs_in[TRANS_BIT] = 1'b1;
                        if (ic_ff[TRANS_BIT]) is_in[TRANS_BIT] = 1'b1;
                     end
                  end
                  ip_in = (is_in != '0) || it_ff;
               end
            end
            default: ;
         endcase
         ovalid_in = 1'b1;
         ores_in.read_data    = rd;
         ores_in.intr_line    = ip_in && ie_in;
         ores_in.wakeup_level = (fs_in & wk_in) != '0;
         ores_in.alert_pulse  = alert;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ip_ff <= 1'b0; ie_ff <= 1'b0; it_ff <= 1'b0; en_ff <= '0;
         pd_ff <= PD_RESET; lp_ff <= 8'd4; np_ff <= NP_RESET; fr_ff <= 1'b0;
         for (int i = 0; i < 16; i++) filt_ff[i] <= '0;
         c0v_ff <= '0; c1v_ff <= '0; c0l_ff <= '0; c1l_ff <= '0;
         wk_ff <= '0; fs_ff <= '0; ic_ff <= '0; is_ff <= '0;
         st_ff <= '0; seen_ff <= 1'b0; ovalid_ff <= 1'b0;
      end else begin
         ip_ff <= ip_in; ie_ff <= ie_in; it_ff <= it_in; en_ff <= en_in;
         pd_ff <= pd_in; lp_ff <= lp_in; np_ff <= np_in; fr_ff <= fr_in;
         filt_ff <= filt_in;
         c0v_ff <= c0v_in; c1v_ff <= c1v_in; c0l_ff <= c0l_in; c1l_ff <= c1l_in;
         wk_ff <= wk_in; fs_ff <= fs_in; ic_ff <= ic_in; is_ff <= is_in;
         st_ff <= st_in; seen_ff <= seen_in; ovalid_ff <= ovalid_in;
      end
      ores_ff <= ores_in;
   end

`ifndef SYNTH
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && !out_ready) |=> $stable(ores_ff)) else $error("result changed");
   a_pend: assert property (@(posedge clock) disable iff (reset)
      (is_ff != '0) |-> ip_ff) else $error("pending lost");
   a_state: assert property (@(posedge clock) disable iff (reset)
      (st_ff == '0 || st_ff == FSM_NP_STATE)) else $error("bad fsm code");
`endif
endmodule
